@@ sv/fsksq_pkg.sv @@
// Shared constants and types for the FSK square-wave chip generator.
package fsksq_pkg;

    // Ticks (chips) generated per data bit
    localparam int TICKS_PER_BIT = 20;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int BITS_W    = 4;
    localparam int CHIP_W    = 20;
    localparam int HP_W      = 6;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = HP_W;
    localparam int IDX_W     = $clog2(BYTE_W);

    // Largest half period and the widest toggle position inside one bit
    localparam int HP_MAX    = (2 ** HP_W) - 1;
    localparam int POS_W     = $clog2(HP_MAX * TICKS_PER_BIT + 1);

    // Chips that actually land in the output word
    localparam int OUT_TICKS = (TICKS_PER_BIT < CHIP_W) ? TICKS_PER_BIT : CHIP_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD_ZERO = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD_ONE  = CFG_IDX_W'(1);

    // Reset values
    localparam logic [HP_W-1:0] HP_ZERO_RST = HP_W'(5);
    localparam logic [HP_W-1:0] HP_ONE_RST  = HP_W'(4);

    // Waveform phase carried from bit to bit
    typedef struct packed {
        logic            level;
        logic [HP_W-1:0] ticks;
    } t_wave;

    // Result of running one data bit
    typedef struct packed {
        t_wave             wave;
        logic [CHIP_W-1:0] chips;
    } t_bit_res;

endpackage

@@ sv/fsksq_if.sv @@
// Valid/ready channel interfaces for byte input, chip output and register writes.
interface fsksq_in_if
    import fsksq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic [BITS_W-1:0] bits_valid;
    logic              packet_start;

    modport source (output valid, data_byte, bits_valid, packet_start, input ready);
    modport sink   (input valid, data_byte, bits_valid, packet_start, output ready);
endinterface

interface fsksq_out_if
    import fsksq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHIP_W-1:0] chips;
    logic              last_of_byte;

    modport source (output valid, chips, last_of_byte, input ready);
    modport sink   (input valid, chips, last_of_byte, output ready);
endinterface

interface fsksq_cfg_if
    import fsksq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/fsk_square_wave_chip_generator.sv @@
// Top level of the continuous-phase FSK square-wave chip generator.
//
// Each input word is a packet byte whose low bits_valid bits (capped at 8) are sent
// LSB first; every data bit yields one output word of TICKS_PER_BIT square-wave chips
// (bit 0 earliest), with last_of_byte set on the final bit. One output word leaves per
// cycle while the output side is ready: a byte with n bits gives n output words (a
// byte with no bits is taken but gives no output), and the next byte is taken in the cycle
// its predecessor's last bit is produced. That rate is set by the bit stepper, which
// runs all ticks of one bit combinationally and feeds level and tick count straight
// back for the next bit. The output register lets a new bit be computed in the same
// cycle the waiting word is taken. Half periods are written over the cfg channel,
// which is always ready; write them only while the generator is idle.
module fsk_square_wave_chip_generator
    import fsksq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    fsksq_cfg_if.sink   i_cfg,
    fsksq_in_if.sink    i_data,
    fsksq_out_if.source o_chip
);

    // Runs every tick of one data bit. Toggles are periodic in the half period,
    // so the toggle positions are laid out first and each chip level is the start
    // level flipped by the parity of the toggles that precede it.
    function automatic t_bit_res run_bit(t_wave wave, logic [HP_W-1:0] half);
        logic [HP_W-1:0]          hp;
        logic [HP_W-1:0]          t0;
        logic [POS_W-1:0]         pos;
        logic [TICKS_PER_BIT-1:0] tog;
        logic [TICKS_PER_BIT-1:0] msk;
        t_bit_res                 res;
        // a zero half period toggles on every tick
        hp = (half == '0) ? HP_W'(1) : half;
        // tick index after which the first toggle happens
        if (wave.ticks == HP_W'(HP_MAX) && half != '0) begin
            // counter wraps to zero on the first tick, then counts up again
            t0 = hp;
        end else if (({1'b0, wave.ticks} + 7'd1) >= {1'b0, hp}) begin
            t0 = '0;
        end else begin
            t0 = hp - wave.ticks - HP_W'(1);
        end
        // mark every tick that ends with a toggle
        tog = '0;
        for (int k = 0; k < TICKS_PER_BIT; k++) begin
            pos = POS_W'(t0) + POS_W'(k) * POS_W'(hp);
            for (int j = 0; j < TICKS_PER_BIT; j++) begin
                if (pos == POS_W'(j)) begin
                    tog[j] = 1'b1;
                end
            end
        end
        // chip level = start level xor parity of earlier toggles
        res.chips = '0;
        for (int t = 0; t < OUT_TICKS; t++) begin
            msk = (TICKS_PER_BIT'(1) << t) - TICKS_PER_BIT'(1);
            res.chips[t] = wave.level ^ (^(tog & msk));
        end
        res.wave.level = wave.level ^ (^tog);
        // tick count after the bit: ticks since the last toggle
        res.wave.ticks = wave.ticks + HP_W'(TICKS_PER_BIT);
        for (int j = 0; j < TICKS_PER_BIT; j++) begin
            if (tog[j]) begin
                res.wave.ticks = HP_W'(TICKS_PER_BIT - 1 - j);
            end
        end
        return res;
    endfunction

    // Registers
    logic [HP_W-1:0]   r_hp0, n_hp0;
    logic [HP_W-1:0]   r_hp1, n_hp1;
    t_wave             r_wave, n_wave;
    logic              r_busy, n_busy;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic [BITS_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic [CHIP_W-1:0] r_out_chips, n_out_chips;
    logic              r_out_last, n_out_last;

    logic              advance;
    logic              last_bit;
    logic              in_ready;
    logic              cur_bit;
    logic [BITS_W-1:0] in_cnt;
    t_bit_res          bit_res;

    // Handshake and bit selection
    always_comb begin
        advance  = r_busy && (!r_out_valid || o_chip.ready);
        last_bit = ({1'b0, r_idx} + BITS_W'(1)) == r_cnt;
        in_ready = !r_busy || (advance && last_bit);
        cur_bit  = r_byte[r_idx];
        in_cnt   = (i_data.bits_valid > BITS_W'(BYTE_W)) ? BITS_W'(BYTE_W) : i_data.bits_valid;
        bit_res  = run_bit(r_wave, cur_bit ? r_hp1 : r_hp0);
    end

    // Next state
    always_comb begin
        n_hp0       = r_hp0;
        n_hp1       = r_hp1;
        n_wave      = r_wave;
        n_busy      = r_busy;
        n_byte      = r_byte;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_chips = r_out_chips;
        n_out_last  = r_out_last;

        // output word taken
        if (r_out_valid && o_chip.ready) begin
            n_out_valid = 1'b0;
        end

        // produce one bit
        if (advance) begin
            n_out_valid = 1'b1;
            n_out_chips = bit_res.chips;
            n_out_last  = last_bit;
            n_wave      = bit_res.wave;
            n_idx       = r_idx + IDX_W'(1);
            if (last_bit) begin
                n_busy = 1'b0;
            end
        end

        // take a new byte; packet start restarts the phase
        if (i_data.valid && in_ready) begin
            n_byte = i_data.data_byte;
            n_cnt  = in_cnt;
            n_idx  = '0;
            n_busy = (in_cnt != '0);
            if (i_data.packet_start) begin
                n_wave.level = 1'b1;
                n_wave.ticks = '0;
            end
        end

        // register writes
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_HALF_PERIOD_ZERO: n_hp0 = i_cfg.data;
                CFG_HALF_PERIOD_ONE:  n_hp1 = i_cfg.data;
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp0       <= HP_ZERO_RST;
            r_hp1       <= HP_ONE_RST;
            r_wave      <= '{level: 1'b1, ticks: '0};
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_hp0       <= n_hp0;
            r_hp1       <= n_hp1;
            r_wave      <= n_wave;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_cnt       <= n_cnt;
        r_idx       <= n_idx;
        r_out_chips <= n_out_chips;
        r_out_last  <= n_out_last;
    end

    // Ports
    assign i_cfg.ready         = 1'b1;
    assign i_data.ready        = in_ready;
    assign o_chip.valid        = r_out_valid;
    assign o_chip.chips        = r_out_chips;
    assign o_chip.last_of_byte = r_out_last;

endmodule

@@ tb/sv/fsksq_chip_checker.sv @@
// Watches the byte, chip and register channels, predicts chip words and compares them.
`timescale 1ns / 100ps

module fsksq_chip_checker
    import fsksq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    fsksq_cfg_if  cfg_mon,
    fsksq_in_if   in_mon,
    fsksq_out_if  out_mon,
    output int    o_fail_count,
    output int    o_pending
);

    // One expected output word
    typedef struct packed {
        logic [CHIP_W-1:0] chips;
        logic              last;
    } t_chip_word;

    t_chip_word chips_due[$];

    // Predicted modulator phase and the half periods in force
    logic            lvl_now;
    logic [HP_W-1:0] tick_cnt;
    logic [HP_W-1:0] hp_zero;
    logic [HP_W-1:0] hp_one;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Steps the square wave through one data bit and collects its chips
    function automatic logic [CHIP_W-1:0] wave_chips(logic data_bit);
        logic [HP_W-1:0]   half;
        logic [CHIP_W-1:0] pattern;
        half    = data_bit ? hp_one : hp_zero;
        pattern = '0;
        for (int t = 0; t < TICKS_PER_BIT; t++) begin
            if (t < CHIP_W && lvl_now) begin
                pattern[t] = 1'b1;
            end
            tick_cnt = tick_cnt + 1'b1;
            // a half period of zero compares true on every tick
            if (tick_cnt >= half) begin
                lvl_now  = ~lvl_now;
                tick_cnt = '0;
            end
        end
        return pattern;
    endfunction

    // Queues the chip words one accepted byte will produce
    function automatic void expand_byte(logic [BYTE_W-1:0] data_in,
                                        logic [BITS_W-1:0] nbits, logic restart);
        int         count;
        t_chip_word word;
        if (restart) begin
            lvl_now  = 1'b1;
            tick_cnt = '0;
        end
        // more than eight bits saturates
        count = (nbits > BYTE_W) ? BYTE_W : int'(nbits);
        for (int k = 0; k < count; k++) begin
            word.chips = wave_chips(data_in[k]);
            word.last  = (k == count - 1);
            chips_due.push_back(word);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_chip_word want;
        if (!i_rst_n) begin
            lvl_now  = 1'b1;
            tick_cnt = '0;
            hp_zero  = HP_ZERO_RST;
            hp_one   = HP_ONE_RST;
            chips_due.delete();
        end else begin
            // register writes; unmapped indexes fall through
            if (cfg_mon.valid && cfg_mon.ready) begin
                if (cfg_mon.index == CFG_HALF_PERIOD_ZERO) begin
                    hp_zero = cfg_mon.data;
                end else if (cfg_mon.index == CFG_HALF_PERIOD_ONE) begin
                    hp_one = cfg_mon.data;
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                expand_byte(in_mon.data_byte, in_mon.bits_valid, in_mon.packet_start);
            end
            // compare each taken word with the oldest prediction
            if (out_mon.valid && out_mon.ready) begin
                if (chips_due.size() == 0) begin
                    $error("unexpected word: chips %05h last_of_byte %0b",
                           out_mon.chips, out_mon.last_of_byte);
                    o_fail_count++;
                end else begin
                    want = chips_due.pop_front();
                    if (out_mon.chips !== want.chips) begin
                        $error("chips: expected %05h, actual %05h", want.chips, out_mon.chips);
                        o_fail_count++;
                    end
                    if (out_mon.last_of_byte !== want.last) begin
                        $error("last_of_byte: expected %0b, actual %0b",
                               want.last, out_mon.last_of_byte);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = chips_due.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
// Stimulus, clocking and verdict for the FSK square-wave chip generator.
`timescale 1ns / 100ps

module testbench
    import fsksq_pkg::*;
();

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE_TICKS = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_BYTES  = 45;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [BITS_W-1:0] bits_valid;
        logic              packet_start;
    } t_byte_item;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_total;
    int   words_owed;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_req;

    fsksq_cfg_if cfg_ch ();
    fsksq_in_if  in_ch ();
    fsksq_out_if out_ch ();

    fsk_square_wave_chip_generator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_data  (in_ch),
        .o_chip  (out_ch)
    );

    fsksq_chip_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cfg_mon      (cfg_ch),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .o_fail_count (fail_total),
        .o_pending    (words_owed)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAILED: results differ");
        $finish;
    end

    // Chip receiver: random stall bursts, plus one long hold on request
    initial begin
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if ($urandom_range(0, 99) < recv_idle_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Register write; the port accepts when valid and ready meet at a rising edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Offers one byte word, with an optional idle burst ahead of it
    task automatic send_byte(t_byte_item it);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= it.data_byte;
        in_ch.bits_valid   <= it.bits_valid;
        in_ch.packet_start <= it.packet_start;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drops valid and waits until every predicted word has been taken
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (words_owed != 0) @(negedge i_clk);
        // a byte with no bits may still be in flight
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    function automatic t_byte_item rand_byte();
        t_byte_item it;
        int         sel;
        sel            = $urandom_range(0, 19);
        it.data_byte   = BYTE_W'($urandom_range(0, 255));
        if (sel == 0) begin
            it.bits_valid = '0;
        end else if (sel == 1) begin
            it.bits_valid = BITS_W'($urandom_range(BYTE_W + 1, (1 << BITS_W) - 1));
        end else begin
            it.bits_valid = BITS_W'($urandom_range(1, BYTE_W));
        end
        it.packet_start = ($urandom_range(0, 9) == 0);
        return it;
    endfunction

    initial begin
        t_byte_item seed_words[$];
        t_byte_item it;
        logic [CFG_DAT_W-1:0] hp0;
        logic [CFG_DAT_W-1:0] hp1;

        i_rst_n            = 1'b0;
        hold_req           = 1'b0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_HALF_PERIOD_ZERO;
        cfg_ch.data        = '0;
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = '0;
        in_ch.bits_valid   = '0;
        in_ch.packet_start = 1'b0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes at reset half periods: extremes, no-bit and saturated counts
        seed_words = '{
            '{8'h00, 4'd8,  1'b1}, '{8'hFF, 4'd8,  1'b0}, '{8'hAA, 4'd8,  1'b0},
            '{8'h55, 4'd8,  1'b0}, '{8'h01, 4'd1,  1'b0}, '{8'h80, 4'd8,  1'b0},
            '{8'h00, 4'd0,  1'b0}, '{8'hFF, 4'd0,  1'b1}, '{8'h0F, 4'd9,  1'b0},
            '{8'hF0, 4'd15, 1'b0}, '{8'h3C, 4'd4,  1'b1}, '{8'hC3, 4'd7,  1'b0},
            '{8'h5A, 4'd2,  1'b0}, '{8'hFF, 4'd3,  1'b1}, '{8'h00, 4'd5,  1'b0}
        };
        recv_idle_pct = 30;
        send_idle_pct = 30;
        foreach (seed_words[i]) send_byte(seed_words[i]);
        drain();

        // Zero half periods toggle every tick; an unmapped write must change nothing
        write_reg(CFG_HALF_PERIOD_ZERO, '0);
        write_reg(CFG_HALF_PERIOD_ONE, '0);
        write_reg(CFG_IDX_W'($urandom_range(CFG_HALF_PERIOD_ONE + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DAT_W'(HP_MAX));
        send_byte('{8'hA5, 4'd8, 1'b0});
        send_byte('{8'h0F, 4'd8, 1'b1});
        drain();

        // Random phases, each under its own half periods
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin hp0 = 6'd1;  hp1 = 6'd63; end
                1: begin hp0 = 6'd63; hp1 = 6'd1;  end
                2: begin hp0 = 6'd0;  hp1 = 6'd63; end
                3: begin hp0 = 6'd63; hp1 = 6'd63; end
                4: begin hp0 = 6'd2;  hp1 = 6'd0;  end
                default: begin
                    hp0 = CFG_DAT_W'($urandom_range(0, HP_MAX));
                    hp1 = CFG_DAT_W'($urandom_range(0, HP_MAX));
                end
            endcase
            // phase 5 leaves one register alone so the old counter meets a new period
            write_reg(CFG_HALF_PERIOD_ZERO, hp0);
            if (p != 5) begin
                write_reg(CFG_HALF_PERIOD_ONE, hp1);
            end

            // idling varies; the last phases run flat out
            if (p >= PHASES - 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = $urandom_range(0, 2) * 25;
                recv_idle_pct = $urandom_range(0, 2) * 25;
            end
            if (p == 3) begin
                hold_req      = 1'b1;
                send_idle_pct = 0;
            end

            for (int n = 0; n < PHASE_BYTES; n++) begin
                it = rand_byte();
                // half the phases keep the phase carried over from before the write
                if (n == 0) begin
                    it.packet_start = p[0];
                end
                send_byte(it);
            end
            drain();
        end

        if (fail_total == 0 && words_owed == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ fsk_square_wave_chip_generator.f @@
sv/fsksq_pkg.sv
sv/fsksq_if.sv
sv/fsk_square_wave_chip_generator.sv
tb/sv/fsksq_chip_checker.sv
tb/sv/testbench.sv
